/* rtl/core/msm_pkg.sv */
package msm_pkg;

   // fixed field widths
   localparam int ELEM_W    = 11;
   localparam int OUT_W     = 23;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 4;

   // output range of best_sum
   localparam int OUT_MAX_VAL = 4194303;
   localparam int OUT_MIN_VAL = -4194304;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SEARCH,
      ST_DRAIN
   } msm_state_type;

endpackage

/* rtl/core/msm_ram.sv */
module msm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/max_submatrix_sum.sv */
// max_submatrix_sum: largest sum over all non-empty rectangles of a signed matrix
//
// req channel: one element per item (req_element_value), row-major order.
//   an item is taken at a clock edge with req_valid high and req_stall low.
//   loading runs at one item per cycle.
// rsp channel: one item (rsp_best_sum) after the last element of the matrix,
//   taken at an edge with rsp_valid high and rsp_stall low. the result sits in
//   an output register; loading of the next matrix may go on while it waits.
// csr channel: csr_index 0 = row_count, 1 = column_count, taken when csr_valid
//   and csr_ready are high. any write restarts loading at the top-left element.
//   0 acts as 1, a value above MAX_DIM acts as MAX_DIM.
// search: starts after the last element and issues one store read per cycle;
//   the single read port of the matrix store sets this rate. rsp_valid rises
//   once the pipeline has drained. req_stall and csr_ready hold off new items
//   while searching and draining. if the previous result is still stalled at
//   the end of a search, the new result waits for it.
// reset: synchronous, active high. both dimensions return to 1, loading starts
//   at element zero, no result is pending. no memory clearing is needed.
// structure: the matrix sits in one ram, the per-column running sums of the
//   current top row in a second ram; a three stage add/scan/best pipeline
//   runs a max subarray scan over the column sums of each row band.
module max_submatrix_sum #(
   parameter int MAX_DIM = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [msm_pkg::ELEM_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [msm_pkg::OUT_W-1:0]  rsp_best_sum,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [msm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [msm_pkg::CFG_W-1:0]         csr_data
);

   import msm_pkg::*;

   // derived sizes
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;   // row / column index
   localparam int DIMC_W = $clog2(MAX_DIM + 1);                    // row / column count
   localparam int PROD_W = 2 * DIMC_W;
   localparam int ACC_W  = DIM_W + ELEM_W;                         // column sum
   localparam int RUN_W  = 2 * DIM_W + ELEM_W + 1;                 // rectangle sum
   localparam int SAT_W  = (RUN_W > OUT_W) ? RUN_W : OUT_W;
   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(OUT_MAX_VAL);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(OUT_MIN_VAL);

   // clamp a dimension register to 1..MAX_DIM
   function automatic logic [DIMC_W-1:0] eff_dim(input logic [CFG_W-1:0] value);
      logic [DIMC_W-1:0] result;
      if (value == '0) begin
         result = DIMC_W'(1);
      end else if (32'(value) > MAX_DIM) begin
         result = DIMC_W'(MAX_DIM);
      end else begin
         result = DIMC_W'(value);
      end
      return result;
   endfunction

   // control state
   msm_state_type state_ff, state_in;
   logic [CFG_W-1:0]  row_count_ff, row_count_in;
   logic [CFG_W-1:0]  column_count_ff, column_count_in;
   logic [ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_sum_ff, rsp_sum_in;

   // search counters
   logic [DIM_W-1:0]  top_ff, top_in;
   logic [DIM_W-1:0]  bottom_ff, bottom_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] base_ff, base_in;

   // pipeline
   logic              s1_v_ff, s1_v_in;
   logic              s1_first_ff, s1_first_in;
   logic [DIM_W-1:0]  s1_col_ff, s1_col_in;
   logic              fwd_v_ff, fwd_v_in;
   logic [DIM_W-1:0]  fwd_col_ff, fwd_col_in;
   logic signed [ACC_W-1:0] fwd_acc_ff, fwd_acc_in;
   logic              s2_v_ff, s2_v_in;
   logic              s2_col0_ff, s2_col0_in;
   logic signed [ACC_W-1:0] s2_acc_ff, s2_acc_in;
   logic              s3_v_ff, s3_v_in;
   logic signed [RUN_W-1:0] run_ff, run_in;
   logic signed [RUN_W-1:0] best_ff, best_in;
   logic              seeded_ff, seeded_in;

   // combinational
   logic [DIMC_W-1:0] rows_eff, cols_eff;
   logic [DIM_W-1:0]  last_row, last_col;
   logic [PROD_W-1:0] total_last;
   logic              req_accept, csr_accept, last_elem, start_search;
   logic              col_last, row_last, top_last, issue_done, pipe_empty, finish;
   logic signed [ELEM_W-1:0] store_rd_data;
   logic signed [ACC_W-1:0]  acc_rd_data, acc_base, acc_new;
   logic signed [SAT_W-1:0]  best_ext;

   assign rows_eff   = eff_dim(row_count_ff);
   assign cols_eff   = eff_dim(column_count_ff);
   assign last_row   = DIM_W'(rows_eff - DIMC_W'(1));
   assign last_col   = DIM_W'(cols_eff - DIMC_W'(1));
   assign total_last = PROD_W'(rows_eff) * PROD_W'(cols_eff) - PROD_W'(1);

   assign req_stall    = (state_ff != ST_LOAD);
   assign csr_ready    = (state_ff == ST_LOAD);
   assign req_accept   = req_valid && !req_stall;
   assign csr_accept   = csr_valid && csr_ready;
   assign last_elem    = (PROD_W'(load_pos_ff) == total_last);
   assign start_search = req_accept && last_elem && !csr_accept;

   assign col_last   = (col_ff == last_col);
   assign row_last   = (bottom_ff == last_row);
   assign top_last   = (top_ff == last_row);
   assign issue_done = (state_ff == ST_SEARCH) && col_last && row_last && top_last;
   assign pipe_empty = !s1_v_ff && !s2_v_ff && !s3_v_ff;
   assign finish     = (state_ff == ST_DRAIN) && pipe_empty && !rsp_valid_ff;

   // matrix store: loader writes, search reads
   msm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (load_pos_ff),
      .wr_data (req_element_value),
      .rd_addr (addr_ff),
      .rd_data (store_rd_data)
   );

   // column sums of the current row band
   msm_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_DIM)
   ) u_col_acc (
      .clock   (clock),
      .wr_en   (s1_v_ff),
      .wr_addr (s1_col_ff),
      .wr_data (acc_new),
      .rd_addr (col_ff),
      .rd_data (acc_rd_data)
   );

   // state machine, configuration and result register
   always_comb begin
      state_in        = state_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      load_pos_in     = load_pos_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sum_in      = rsp_sum_ff;

      if (csr_accept) begin
         if (csr_index == REG_ROW_COUNT) begin
            row_count_in = csr_data;
         end else if (csr_index == REG_COLUMN_COUNT) begin
            column_count_in = csr_data;
         end
         // any write restarts the load
         load_pos_in = '0;
      end else if (req_accept) begin
         load_pos_in = last_elem ? '0 : load_pos_ff + ADDR_W'(1);
      end

      case (state_ff)
         ST_LOAD: begin
            if (start_search) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (issue_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in     = ST_LOAD;
               rsp_valid_in = 1'b1;
               // saturate to the output range
               if (best_ext > SAT_HI) begin
                  rsp_sum_in = OUT_W'(SAT_HI);
               end else if (best_ext < SAT_LO) begin
                  rsp_sum_in = OUT_W'(SAT_LO);
               end else begin
                  rsp_sum_in = OUT_W'(best_ext);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign best_ext = SAT_W'(best_ff);

   // search walk: top row, bottom row, column
   always_comb begin
      top_in    = top_ff;
      bottom_in = bottom_ff;
      col_in    = col_ff;
      addr_in   = addr_ff;
      base_in   = base_ff;

      if (state_ff == ST_LOAD && start_search) begin
         top_in    = '0;
         bottom_in = '0;
         col_in    = '0;
         addr_in   = '0;
         base_in   = '0;
      end else if (state_ff == ST_SEARCH) begin
         if (!col_last) begin
            col_in  = col_ff + DIM_W'(1);
            addr_in = addr_ff + ADDR_W'(1);
         end else if (!row_last) begin
            col_in    = '0;
            bottom_in = bottom_ff + DIM_W'(1);
            addr_in   = addr_ff + ADDR_W'(1);
         end else if (!top_last) begin
            // next band starts one row lower
            col_in    = '0;
            top_in    = top_ff + DIM_W'(1);
            bottom_in = top_ff + DIM_W'(1);
            base_in   = base_ff + ADDR_W'(cols_eff);
            addr_in   = base_ff + ADDR_W'(cols_eff);
         end
      end
   end

   // read / accumulate / scan / best pipeline
   always_comb begin
      // stage 1: ram data back, new column sum
      s1_v_in     = (state_ff == ST_SEARCH);
      s1_first_in = (bottom_ff == top_ff);
      s1_col_in   = col_ff;

      // a single column rereads its entry the next cycle: forward the write
      if (s1_first_ff) begin
         acc_base = '0;
      end else if (fwd_v_ff && (fwd_col_ff == s1_col_ff)) begin
         acc_base = fwd_acc_ff;
      end else begin
         acc_base = acc_rd_data;
      end
      acc_new = acc_base + ACC_W'(store_rd_data);

      fwd_v_in   = s1_v_ff;
      fwd_col_in = s1_col_ff;
      fwd_acc_in = acc_new;

      s2_v_in    = s1_v_ff;
      s2_col0_in = (s1_col_ff == '0);
      s2_acc_in  = acc_new;

      // stage 2: max subarray scan along the band
      s3_v_in = s2_v_ff;
      run_in  = run_ff;
      if (s2_v_ff) begin
         if (s2_col0_ff || (run_ff < 0)) begin
            run_in = RUN_W'(s2_acc_ff);
         end else begin
            run_in = run_ff + RUN_W'(s2_acc_ff);
         end
      end

      // stage 3: keep the best, seeded by the first rectangle
      best_in   = best_ff;
      seeded_in = seeded_ff;
      if (start_search) begin
         seeded_in = 1'b0;
      end else if (s3_v_ff && (!seeded_ff || (run_ff > best_ff))) begin
         best_in   = run_ff;
         seeded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         row_count_ff    <= CFG_W'(1);
         column_count_ff <= CFG_W'(1);
         load_pos_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         s1_v_ff         <= 1'b0;
         s2_v_ff         <= 1'b0;
         s3_v_ff         <= 1'b0;
         fwd_v_ff        <= 1'b0;
         seeded_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         load_pos_ff     <= load_pos_in;
         rsp_valid_ff    <= rsp_valid_in;
         s1_v_ff         <= s1_v_in;
         s2_v_ff         <= s2_v_in;
         s3_v_ff         <= s3_v_in;
         fwd_v_ff        <= fwd_v_in;
         seeded_ff       <= seeded_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_sum_ff  <= rsp_sum_in;
      top_ff      <= top_in;
      bottom_ff   <= bottom_in;
      col_ff      <= col_in;
      addr_ff     <= addr_in;
      base_ff     <= base_in;
      s1_first_ff <= s1_first_in;
      s1_col_ff   <= s1_col_in;
      fwd_col_ff  <= fwd_col_in;
      fwd_acc_ff  <= fwd_acc_in;
      s2_col0_ff  <= s2_col0_in;
      s2_acc_ff   <= s2_acc_in;
      run_ff      <= run_in;
      best_ff     <= best_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = rsp_sum_ff;

endmodule

/* tb/sv/msm_checker.sv */
`timescale 1ns / 1ps
module msm_checker
   import msm_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [OUT_W-1:0]  rsp_best_sum,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_data,
   output int                       mismatch_count,
   output int                       results_pending,
   output int                       results_seen
);

   logic signed [ELEM_W-1:0] matrix_copy [MAX_DIM*MAX_DIM];
   logic [CFG_W-1:0]         rows_reg;
   logic [CFG_W-1:0]         cols_reg;
   int                       fill_pos;
   logic signed [OUT_W-1:0]  sums_due [$];

   function automatic int dim_in_use(input logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   // fix a top and bottom row, sum the columns between them, scan for the best run
   function automatic logic signed [OUT_W-1:0] best_rectangle_sum(input int rows,
                                                                  input int cols);
      longint col_sum [MAX_DIM];
      longint run;
      longint best;
      bit     seeded;
      best   = 0;
      seeded = 1'b0;
      for (int top = 0; top < rows; top++) begin
         for (int c = 0; c < cols; c++) col_sum[c] = 0;
         for (int bottom = top; bottom < rows; bottom++) begin
            run = 0;
            for (int c = 0; c < cols; c++) begin
               col_sum[c] += matrix_copy[bottom*cols + c];
               if (c == 0 || run < 0) run = col_sum[c];
               else run += col_sum[c];
               if (!seeded || run > best) begin
                  best   = run;
                  seeded = 1'b1;
               end
            end
         end
      end
      if (best > OUT_MAX_VAL) best = OUT_MAX_VAL;
      if (best < OUT_MIN_VAL) best = OUT_MIN_VAL;
      return OUT_W'(best);
   endfunction

   always @(posedge clock) begin
      int                      rows;
      int                      cols;
      logic signed [OUT_W-1:0] due;
      if (reset) begin
         rows_reg       = CFG_W'(1);
         cols_reg       = CFG_W'(1);
         fill_pos       = 0;
         mismatch_count = 0;
         results_seen   = 0;
         sums_due.delete();
      end else begin
         // any write, known index or not, restarts the load
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ROW_COUNT) rows_reg = csr_data;
            else if (csr_index == REG_COLUMN_COUNT) cols_reg = csr_data;
            fill_pos = 0;
         end
         if (req_valid && !req_stall) begin
            rows = dim_in_use(rows_reg);
            cols = dim_in_use(cols_reg);
            if (fill_pos >= rows*cols) fill_pos = 0;
            matrix_copy[fill_pos] = req_element_value;
            fill_pos++;
            if (fill_pos >= rows*cols) begin
               fill_pos = 0;
               sums_due.push_back(best_rectangle_sum(rows, cols));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (sums_due.size() == 0) begin
               $display("%0t ns: unexpected best_sum %0d, expected none",
                        $time, rsp_best_sum);
               mismatch_count++;
            end else begin
               due = sums_due.pop_front();
               if (rsp_best_sum !== due) begin
                  $display("%0t ns: best_sum mismatch, expected %0d, got %0d",
                           $time, due, rsp_best_sum);
                  mismatch_count++;
               end
            end
         end
      end
      results_pending = sums_due.size();
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import msm_pkg::*;

   localparam int MAX_DIM      = 64;
   // longest quiet stretch is the search of a 64x2 matrix
   localparam int IDLE_LIMIT   = 20000;
   localparam int SETTLE_GAP   = 8;      // lets the search pipeline drain
   localparam int END_GAP      = 50;
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
   localparam int PHASE_ITEMS  = 280;
   // an index past the register list, only restarts the load
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(9);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]  rsp_best_sum;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CFG_W-1:0]         csr_data = '0;

   int mismatch_count;
   int results_pending;
   int results_seen;

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // long hold-off orders, served by the receiver process
   int hold_orders   = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   // dimensions as last written, used to size each matrix
   logic [CFG_W-1:0] cur_rows = CFG_W'(1);
   logic [CFG_W-1:0] cur_cols = CFG_W'(1);

   int elements_sent = 0;
   int csr_writes    = 0;
   int quiet_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   max_submatrix_sum #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_best_sum      (rsp_best_sum),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   msm_checker #(
      .MAX_DIM(MAX_DIM)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_best_sum      (rsp_best_sum),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .results_pending   (results_pending),
      .results_seen      (results_seen)
   );

   // receiver: a pending hold-off order wins, else random stall
   always @(negedge clock) begin
      if (hold_orders != holds_served) begin
         holds_served = hold_orders;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // watchdog: any handshake restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int dim_in_use(input logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   // mix of value styles so every bit of the element toggles
   function automatic int rand_element();
      int style;
      style = $urandom_range(9);
      case (style)
         0, 1, 2, 3: return int'($urandom_range(2000)) - 1000;
         4:          return int'($urandom_range(2047)) - 1024;
         5, 6:       return int'($urandom_range(16)) - 8;
         7, 8:       return int'($urandom_range(1050)) - 1000;
         default: begin
            case ($urandom_range(3))
               0:       return 1023;
               1:       return -1024;
               2:       return 1000;
               default: return -1000;
            endcase
         end
      endcase
   endfunction

   // entered and left at a falling edge; valid stays up between back-to-back items
   task automatic put_element(input int value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= ELEM_W'(value);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      elements_sent++;
      @(negedge clock);
   endtask

   task automatic put_list(input int values[$]);
      foreach (values[i]) put_element(values[i]);
   endtask

   // one whole matrix of random elements at the current dimensions
   task automatic fill_matrix();
      repeat (dim_in_use(cur_rows) * dim_in_use(cur_cols)) put_element(rand_element());
   endtask

   // drop valid, wait out every result, then let the pipeline settle
   task automatic settle();
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_GAP) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_ROW_COUNT) cur_rows = data;
      else if (index == REG_COLUMN_COUNT) cur_cols = data;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      settle();
      write_csr(REG_ROW_COUNT, rows);
      write_csr(REG_COLUMN_COUNT, cols);
   endtask

   // random matrices; mostly well-formed loads, a few cut short by a register write
   task automatic random_phase(input int send_pct, input int stall_pct, input int target);
      int               start_count;
      int               pick;
      int               shape;
      int               size;
      int               cut;
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      logic [CFG_W-1:0] swap;
      logic [CSR_IDX_W-1:0] index;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      start_count   = elements_sent;
      while (elements_sent - start_count < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // new shape, mostly small
            shape = $urandom_range(99);
            if (shape < 80) begin
               rows = CFG_W'($urandom_range(1, 6));
               cols = CFG_W'($urandom_range(1, 6));
            end else if (shape < 93) begin
               rows = CFG_W'($urandom_range(1, 12));
               cols = CFG_W'($urandom_range(1, 12));
            end else if (shape < 97) begin
               // zero register values act as one
               rows = ($urandom_range(1) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 8));
               cols = ($urandom_range(1) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 8));
            end else begin
               // oversized on one axis, kept thin on the other
               rows = CFG_W'($urandom_range(65, 127));
               cols = CFG_W'($urandom_range(0, 2));
               if ($urandom_range(1) == 1) begin
                  swap = rows;
                  rows = cols;
                  cols = swap;
               end
            end
            set_dims(rows, cols);
         end else if (pick < 45) begin
            // broken load: part of a matrix, then a register write restarts it
            size = dim_in_use(cur_rows) * dim_in_use(cur_cols);
            cut  = (size > 1) ? $urandom_range(1, size - 1) : 0;
            repeat (cut) put_element(rand_element());
            settle();
            index = CSR_IDX_W'($urandom_range(0, 15));
            if (index == REG_ROW_COUNT || index == REG_COLUMN_COUNT)
               write_csr(index, CFG_W'($urandom_range(0, 6)));
            else
               write_csr(index, CFG_W'($urandom_range(0, 127)));
         end else if (pick < 50) begin
            // sender waits for every result before going on
            settle();
         end
         fill_matrix();
      end
      settle();
   endtask

   initial begin
      int seq [$];

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset dimensions are 1x1, element extremes
      seq = '{1023, -1024};
      put_list(seq);
      // zero registers act as one
      set_dims(CFG_W'(0), CFG_W'(0));
      seq = '{-1000, 1000};
      put_list(seq);
      // all negative: best is the single largest element
      set_dims(CFG_W'(2), CFG_W'(3));
      seq = '{-5, -3, -7, -2, -9, -1};
      put_list(seq);
      // write to an index past the list in mid-load restarts the load
      set_dims(CFG_W'(2), CFG_W'(2));
      seq = '{7, 7};
      put_list(seq);
      settle();
      write_csr(REG_SPARE, CFG_W'(7'h55));
      seq = '{4, -1, -6, 3};
      put_list(seq);
      // mixed signs, best rectangle inside the matrix
      set_dims(CFG_W'(3), CFG_W'(3));
      seq = '{1, -10, 2, -10, 5, 5, 3, 5, -20};
      put_list(seq);

      // size extremes; a full 16x16 of maximum elements gives a large positive sum
      set_dims(CFG_W'(16), CFG_W'(16));
      repeat (16*16) put_element(1023);
      set_dims(CFG_W'(1), CFG_W'(64));
      fill_matrix();
      set_dims(CFG_W'(64), CFG_W'(1));
      fill_matrix();
      set_dims(CFG_W'(127), CFG_W'(2));
      fill_matrix();
      set_dims(CFG_W'(3), CFG_W'(100));
      fill_matrix();

      // backpressure: receiver holds off while small matrices keep coming,
      // so a finished search waits on the output and the input stalls
      set_dims(CFG_W'(2), CFG_W'(2));
      @(posedge clock);
      hold_orders++;
      @(negedge clock);
      repeat (24) put_element(rand_element());
      settle();

      // random phases over the idling modes
      random_phase(0, 0, PHASE_ITEMS);
      random_phase(85, 0, PHASE_ITEMS);
      random_phase(0, 85, PHASE_ITEMS);
      random_phase(12, 12, PHASE_ITEMS);

      // drain and let any stray result show up
      rsp_stall_pct = 0;
      settle();
      repeat (END_GAP) @(posedge clock);

      $display("covered %0d elements, %0d results, %0d register writes",
               elements_sent, results_seen, csr_writes);
      $display("shapes 1x1 up to 64 on a side incl. zero and oversized registers, four idling modes");
      if (results_pending != 0)
         $display("%0t ns: %0d best_sum results never arrived", $time, results_pending);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* max_submatrix_sum.f */
rtl/core/msm_pkg.sv
rtl/core/msm_ram.sv
rtl/core/max_submatrix_sum.sv
tb/sv/msm_checker.sv
tb/sv/tb_top.sv
